>>> sv/isotp_pkg.sv
// shared constants, types and helpers for the segmented sender
package isotp_pkg;

  localparam int PAYLOAD_MAX = 64;
  localparam int LEN_W = $clog2(PAYLOAD_MAX + 1);
  localparam int HEAD_BYTES = 6;
  localparam int CF_BYTES = 7;
  localparam int ROWS = PAYLOAD_MAX / CF_BYTES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_BITS = CF_BYTES * 8;
  localparam int HEAD_IDX_W = $clog2(HEAD_BYTES);
  localparam int LANE_W = $clog2(CF_BYTES);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] EV_FRAME   = 2'd0;
  localparam logic [1:0] EV_TIMEOUT = 2'd1;
  localparam logic [1:0] EV_ABORT   = 2'd2;

  localparam logic [1:0] CFG_TX_ID      = 2'd0;
  localparam logic [1:0] CFG_FC_SRC_ID  = 2'd1;
  localparam logic [1:0] CFG_FC_TIMEOUT = 2'd2;

  localparam logic [3:0] FC_CTS   = 4'h0;
  localparam logic [3:0] FC_WAIT  = 4'h1;
  localparam logic [3:0] FC_ABORT = 4'h2;

  localparam logic [7:0] PCI_FF = 8'h10;
  localparam logic [7:0] PCI_CF = 8'h20;
  localparam logic [3:0] PCI_FC_NIBBLE = 4'h3;
  localparam logic [3:0] FC_MIN_LEN = 4'd3;

  localparam logic [7:0] STMIN_MS_MAX = 8'h7F;
  localparam logic [7:0] STMIN_US_LO  = 8'hF1;
  localparam logic [7:0] STMIN_US_HI  = 8'hF9;

  localparam logic [10:0] TX_ID_RST      = 11'd2024;
  localparam logic [10:0] FC_SRC_ID_RST  = 11'd2016;
  localparam logic [15:0] FC_TIMEOUT_RST = 16'd1000;

  typedef logic [ROW_BITS-1:0] row_t;

  function automatic logic [6:0] map_stmin(input logic [7:0] code);
    logic [6:0] r;
    if (code <= STMIN_MS_MAX) r = code[6:0];
    else if (code >= STMIN_US_LO && code <= STMIN_US_HI) r = 7'd1;
    else r = 7'd0;
    return r;
  endfunction

endpackage

>>> sv/isotp_ram.sv
// generic single write port ram with registered read
module isotp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/isotp_segmented_sender.sv
// iso-tp sending side: payload loading, flow control handling, frame output
//
// one input channel carries three kinds of beat: a payload byte (loaded only
// while idle), a received can frame (looked at only while waiting for flow
// control) and a 1 ms tick. a byte marked last starts the transfer: a single
// frame for up to 7 bytes, else a first frame and a wait for flow control.
// consecutive frames then leave one per tick, after separation time and
// block size. each input beat gives at most one output beat: a sent frame,
// a flow control timeout or an abort by the tester.
// a beat is taken every cycle while in_ready is high; its result appears on
// the output register the cycle after acceptance. bytes 0..5 of the payload
// sit in flops, the rest in a ram of 7-byte rows, one row per consecutive
// frame; the row for the next consecutive frame is read ahead of its tick.
// when the output register holds a result that is not taken, in_ready drops
// until it is taken. the config port is always ready.
// reset clears control state and loads the register defaults; no memory
// clearing pass is needed.
module isotp_segmented_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [10:0] rx_id,
  input  logic [3:0]  rx_len,
  input  logic [7:0]  rx_pci,
  input  logic [7:0]  rx_block_size,
  input  logic [7:0]  rx_sep_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_res,
  output logic [10:0] frame_id,
  output logic [63:0] frame_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import isotp_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_SEND} phase_t;

  phase_t phase, phase_next;
  logic [10:0] tx_id, fc_src_id;
  logic [15:0] fc_timeout_ticks;
  logic [LEN_W-1:0] payload_len, payload_len_next;
  logic [LEN_W-1:0] send_offset, send_offset_next;
  logic [ROW_W-1:0] cf_row, cf_row_next;
  logic [ROW_W-1:0] load_row, load_row_next;
  logic [LANE_W-1:0] load_lane, load_lane_next;
  logic [3:0] seq_number, seq_number_next;
  logic [7:0] block_limit, block_limit_next;
  logic [7:0] block_count, block_count_next;
  logic [6:0] sep_ticks, sep_ticks_next;
  logic [7:0] gap_count, gap_count_next;
  logic first_after_fc, first_after_fc_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0] head [HEAD_BYTES];
  logic [7:0] head_next [HEAD_BYTES];
  logic [7:0] asm_row [CF_BYTES];
  logic [7:0] asm_row_next [CF_BYTES];

  logic accept;
  logic emit;
  logic [1:0] emit_ev;
  logic [7:0] fb [8];
  logic [63:0] fb_packed;
  logic ram_we;
  row_t ram_wdata, ram_rdata;

  logic store;
  logic [LEN_W-1:0] len_new;
  logic [11:0] len_ext;
  logic [7:0] gap_inc;
  logic [15:0] wait_inc;
  logic [7:0] bc_inc;
  logic cf_done;
  logic [LEN_W:0] off_ext;
  logic fc_ok;

  assign in_ready = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  isotp_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS), .AW(ROW_W)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_row),
    .wdata (ram_wdata),
    .raddr (cf_row_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    phase_next = phase;
    payload_len_next = payload_len;
    send_offset_next = send_offset;
    cf_row_next = cf_row;
    load_row_next = load_row;
    load_lane_next = load_lane;
    seq_number_next = seq_number;
    block_limit_next = block_limit;
    block_count_next = block_count;
    sep_ticks_next = sep_ticks;
    gap_count_next = gap_count;
    first_after_fc_next = first_after_fc;
    wait_count_next = wait_count;
    head_next = head;
    asm_row_next = asm_row;
    emit = 1'b0;
    emit_ev = EV_FRAME;
    for (int i = 0; i < 8; i++) fb[i] = 8'h00;
    ram_we = 1'b0;
    ram_wdata = '0;
    store = payload_len < LEN_W'(PAYLOAD_MAX);
    len_new = store ? payload_len + LEN_W'(1) : payload_len;
    len_ext = 12'(len_new);
    gap_inc = (gap_count == 8'hFF) ? gap_count : gap_count + 8'd1;
    wait_inc = (wait_count == 16'hFFFF) ? wait_count : wait_count + 16'd1;
    bc_inc = block_count + 8'd1;
    off_ext = {1'b0, send_offset} + (LEN_W+1)'(CF_BYTES);
    cf_done = off_ext >= {1'b0, payload_len};
    fc_ok = (rx_id == fc_src_id) && (rx_len >= FC_MIN_LEN)
            && (rx_pci[7:4] == PCI_FC_NIBBLE);

    if (accept) begin
      case (opcode)
        OP_LOAD: begin
          if (phase == PH_IDLE) begin
            if (store) begin
              if (payload_len < LEN_W'(HEAD_BYTES)) begin
                head_next[payload_len[HEAD_IDX_W-1:0]] = data_byte;
              end else begin
                asm_row_next[load_lane] = data_byte;
                for (int j = 0; j < CF_BYTES; j++) begin
                  ram_wdata[8*j +: 8] = asm_row_next[j];
                end
                if (load_lane == LANE_W'(CF_BYTES - 1) || last_byte
                    || len_new == LEN_W'(PAYLOAD_MAX)) begin
                  ram_we = 1'b1;
                end
                if (load_lane == LANE_W'(CF_BYTES - 1)) begin
                  load_lane_next = '0;
                  load_row_next = load_row + ROW_W'(1);
                end else begin
                  load_lane_next = load_lane + LANE_W'(1);
                end
              end
            end
            payload_len_next = len_new;
            if (last_byte) begin
              emit = 1'b1;
              if (len_new <= LEN_W'(CF_BYTES)) begin
                fb[0] = 8'(len_new);
                for (int i = 0; i < HEAD_BYTES; i++) begin
                  if (LEN_W'(i) < len_new) fb[i+1] = head_next[i];
                end
                if (len_new == LEN_W'(CF_BYTES)) fb[CF_BYTES] = data_byte;
                phase_next = PH_IDLE;
                payload_len_next = '0;
                load_lane_next = '0;
                load_row_next = '0;
              end else begin
                fb[0] = PCI_FF | {4'h0, len_ext[11:8]};
                fb[1] = len_ext[7:0];
                for (int i = 0; i < HEAD_BYTES; i++) fb[i+2] = head_next[i];
                send_offset_next = LEN_W'(HEAD_BYTES);
                cf_row_next = '0;
                seq_number_next = 4'd1;
                block_limit_next = '0;
                block_count_next = '0;
                sep_ticks_next = '0;
                gap_count_next = '0;
                first_after_fc_next = 1'b1;
                wait_count_next = '0;
                phase_next = PH_WAIT;
              end
            end
          end
        end
        OP_FRAME: begin
          if (phase == PH_WAIT && fc_ok) begin
            case (rx_pci[3:0])
              FC_CTS: begin
                block_limit_next = rx_block_size;
                sep_ticks_next = map_stmin(rx_sep_time);
                block_count_next = '0;
                gap_count_next = '0;
                first_after_fc_next = 1'b1;
                phase_next = PH_SEND;
              end
              FC_WAIT: begin
                wait_count_next = '0;
              end
              FC_ABORT: begin
                emit = 1'b1;
                emit_ev = EV_ABORT;
                phase_next = PH_IDLE;
                payload_len_next = '0;
                load_lane_next = '0;
                load_row_next = '0;
              end
              default: begin
              end
            endcase
          end
        end
        OP_TICK: begin
          if (phase == PH_WAIT) begin
            wait_count_next = wait_inc;
            if (wait_inc >= fc_timeout_ticks) begin
              emit = 1'b1;
              emit_ev = EV_TIMEOUT;
              phase_next = PH_IDLE;
              payload_len_next = '0;
              load_lane_next = '0;
              load_row_next = '0;
            end
          end else if (phase == PH_SEND) begin
            if (!first_after_fc) gap_count_next = gap_inc;
            if (first_after_fc || gap_inc >= {1'b0, sep_ticks}) begin
              emit = 1'b1;
              fb[0] = PCI_CF | {4'h0, seq_number};
              seq_number_next = seq_number + 4'd1;
              for (int j = 0; j < CF_BYTES; j++) begin
                if (({1'b0, send_offset} + (LEN_W+1)'(j)) < {1'b0, payload_len}) begin
                  fb[j+1] = ram_rdata[8*j +: 8];
                end
              end
              gap_count_next = '0;
              first_after_fc_next = 1'b0;
              send_offset_next = off_ext[LEN_W-1:0];
              cf_row_next = cf_row + ROW_W'(1);
              if (cf_done) begin
                phase_next = PH_IDLE;
                payload_len_next = '0;
                load_lane_next = '0;
                load_row_next = '0;
                cf_row_next = '0;
              end else if (block_limit != 8'd0) begin
                block_count_next = bc_inc;
                if (bc_inc >= block_limit) begin
                  block_count_next = '0;
                  wait_count_next = '0;
                  phase_next = PH_WAIT;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    for (int i = 0; i < 8; i++) fb_packed[63-8*i -: 8] = fb[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      payload_len <= '0;
      send_offset <= '0;
      cf_row <= '0;
      load_row <= '0;
      load_lane <= '0;
      seq_number <= 4'd1;
      block_limit <= '0;
      block_count <= '0;
      sep_ticks <= '0;
      gap_count <= '0;
      first_after_fc <= 1'b1;
      wait_count <= '0;
      tx_id <= TX_ID_RST;
      fc_src_id <= FC_SRC_ID_RST;
      fc_timeout_ticks <= FC_TIMEOUT_RST;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      payload_len <= payload_len_next;
      send_offset <= send_offset_next;
      cf_row <= cf_row_next;
      load_row <= load_row_next;
      load_lane <= load_lane_next;
      seq_number <= seq_number_next;
      block_limit <= block_limit_next;
      block_count <= block_count_next;
      sep_ticks <= sep_ticks_next;
      gap_count <= gap_count_next;
      first_after_fc <= first_after_fc_next;
      wait_count <= wait_count_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TX_ID:      tx_id <= cfg_data[10:0];
          CFG_FC_SRC_ID:  fc_src_id <= cfg_data[10:0];
          CFG_FC_TIMEOUT: fc_timeout_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    head <= head_next;
    asm_row <= asm_row_next;
    if (emit) begin
      event_res <= emit_ev;
      frame_id <= (emit_ev == EV_FRAME) ? tx_id : 11'd0;
      frame_bytes <= fb_packed;
    end
  end

endmodule
